>>> src/tmcs_pkg.sv
// shared types and constants of the trinomial map cycle statistics unit
`timescale 1ns / 1ps
`default_nettype none
package tmcs_pkg;

   localparam int FIELD_W     = 12;
   localparam int MAX_MODULUS = 4096;
   localparam int ADDR_W      = $clog2(MAX_MODULUS);
   localparam int CNT_W       = $clog2(FIELD_W);

   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   typedef struct packed {
      logic      start;
      field_type multiplicand;
      field_type multiplier;
   } mm_cmd_type;

   typedef struct packed {
      logic      done;
      logic      busy;
      field_type result;
   } mm_rsp_type;

   typedef struct packed {
      logic      seen;
      field_type pos;
      field_type label;
   } visit_type;

endpackage
`default_nettype wire

>>> src/tmcs_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface tmcs_req_if;
   logic                  valid;
   logic                  ready;
   tmcs_pkg::field_type   modulus;
   tmcs_pkg::field_type   constant_term;
   tmcs_pkg::field_type   power_coeff;
   tmcs_pkg::field_type   exponent;

   modport source (output valid, modulus, constant_term, power_coeff, exponent,
                   input ready);
   modport sink   (input valid, modulus, constant_term, power_coeff, exponent,
                   output ready);
endinterface

interface tmcs_rsp_if;
   logic                  valid;
   logic                  ready;
   tmcs_pkg::field_type   root_count;
   tmcs_pkg::field_type   cycle_count;
   tmcs_pkg::field_type   periodic_points;
   tmcs_pkg::field_type   shortest_cycle;
   tmcs_pkg::field_type   longest_cycle;

   modport source (output valid, root_count, cycle_count, periodic_points,
                   shortest_cycle, longest_cycle, input ready);
   modport sink   (input valid, root_count, cycle_count, periodic_points,
                   shortest_cycle, longest_cycle, output ready);
endinterface
`default_nettype wire

>>> src/trinomial_map_cycle_stats_unit.sv
// trinomial map cycle statistics: sequencer, visit memory and counters
//
//   channel | dir | fields
//   req     | in  | modulus, constant_term, power_coeff, exponent
//   rsp     | out | root_count, cycle_count, periodic_points, shortest_cycle, longest_cycle
//
// per element, a request runs s squarings and m multiplies for the set exponent bits,
// all on the shared bit-serial multiplier
// each request clears visit entries 0..p-1, one per cycle, after reducing the constant term
// synchronous reset; no request is taken until the current one is finished
// a finished response waits in its register while the next request is taken
`timescale 1ns / 1ps
`default_nettype none
module trinomial_map_cycle_stats_unit (
   input wire       clock,
   input wire       reset,
   tmcs_req_if.sink   req,
   tmcs_rsp_if.source rsp
);
   import tmcs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RED_A, S_CLEAR, S_READ, S_CHECK, S_POW, S_POW_A, S_POW_B,
      S_MULC, S_SUM, S_DONE
   } state_type;

   state_type   state_ff, state_in;
   field_type   p_ff, p_in, a_ff, a_in, c_ff, c_in, d_ff, d_in;
   field_type   esh_ff, esh_in, acc_ff, acc_in, b_ff, b_in, t_ff, t_in;
   field_type   x_ff, x_in, pos_ff, pos_in, start_ff, start_in;
   field_type   roots_ff, roots_in, cycles_ff, cycles_in, periodic_ff, periodic_in;
   field_type   shortest_ff, shortest_in, longest_ff, longest_in;
   logic        rsp_valid_ff, rsp_valid_in;
   field_type   o_roots_ff, o_roots_in, o_cycles_ff, o_cycles_in;
   field_type   o_periodic_ff, o_periodic_in, o_shortest_ff, o_shortest_in;
   field_type   o_longest_ff, o_longest_in;

   visit_type   mem [MAX_MODULUS];
   visit_type   rd_ff;
   logic        wr_en;
   addr_type    wr_addr;
   visit_type   wr_data;

   mm_cmd_type  mm_cmd;
   mm_rsp_type  mm_rsp;

   field_type          one;
   field_type          len;
   field_type          start_next;
   logic [FIELD_W+1:0] s0, s1, s2, pm;
   field_type          nx;

   tmcs_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (p_ff),
      .cmd     (mm_cmd),
      .rsp     (mm_rsp)
   );

   always_comb begin
      one        = {{(FIELD_W-1){1'b0}}, (p_ff != field_type'(1))};
      len        = pos_ff - rd_ff.pos + field_type'(1);
      start_next = start_ff + field_type'(1);
      pm         = {2'b00, p_ff};
      s0         = {2'b00, a_ff} + {2'b00, x_ff} + {2'b00, t_ff};
      s1         = (s0 >= pm) ? s0 - pm : s0;
      s2         = (s1 >= pm) ? s1 - pm : s1;
      nx         = s2[FIELD_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      a_in          = a_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      esh_in        = esh_ff;
      acc_in        = acc_ff;
      b_in          = b_ff;
      t_in          = t_ff;
      x_in          = x_ff;
      pos_in        = pos_ff;
      start_in      = start_ff;
      roots_in      = roots_ff;
      cycles_in     = cycles_ff;
      periodic_in   = periodic_ff;
      shortest_in   = shortest_ff;
      longest_in    = longest_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      o_roots_in    = o_roots_ff;
      o_cycles_in   = o_cycles_ff;
      o_periodic_in = o_periodic_ff;
      o_shortest_in = o_shortest_ff;
      o_longest_in  = o_longest_ff;
      mm_cmd        = '{start: 1'b0, multiplicand: one, multiplier: a_ff};
      wr_en         = 1'b0;
      wr_addr       = x_ff;
      wr_data       = '{seen: 1'b0, pos: '0, label: '0};

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               p_in        = req.modulus;
               a_in        = req.constant_term;
               c_in        = req.power_coeff;
               d_in        = req.exponent;
               roots_in    = '0;
               cycles_in   = '0;
               periodic_in = '0;
               shortest_in = '0;
               longest_in  = '0;
               x_in        = '0;
               state_in    = (req.modulus == '0) ? S_DONE : S_RED_A;
            end
         end
         S_RED_A: begin
            // reduce the constant term once per request
            mm_cmd.start = !mm_rsp.busy && !mm_rsp.done;
            if (mm_rsp.done) begin
               a_in     = mm_rsp.result;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            wr_en = 1'b1;
            if (x_ff == p_ff - field_type'(1)) begin
               x_in     = '0;
               start_in = '0;
               pos_in   = '0;
               state_in = S_READ;
            end else begin
               x_in = x_ff + field_type'(1);
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (rd_ff.seen) begin
               if (rd_ff.label == start_ff) begin
                  cycles_in   = cycles_ff + field_type'(1);
                  periodic_in = periodic_ff + len;
                  if (len > longest_ff) longest_in = len;
                  if (shortest_ff == '0 || len < shortest_ff) shortest_in = len;
               end
               if (start_next == p_ff) begin
                  state_in = S_DONE;
               end else begin
                  start_in = start_next;
                  x_in     = start_next;
                  pos_in   = '0;
                  state_in = S_READ;
               end
            end else begin
               acc_in   = one;
               b_in     = x_ff;
               esh_in   = d_ff;
               state_in = S_POW;
            end
         end
         S_POW: begin
            mm_cmd.start = 1'b1;
            if (esh_ff == '0) begin
               mm_cmd.multiplicand = acc_ff;
               mm_cmd.multiplier   = c_ff;
               state_in            = S_MULC;
            end else if (esh_ff[0]) begin
               mm_cmd.multiplicand = acc_ff;
               mm_cmd.multiplier   = b_ff;
               state_in            = S_POW_A;
            end else begin
               mm_cmd.multiplicand = b_ff;
               mm_cmd.multiplier   = b_ff;
               state_in            = S_POW_B;
            end
         end
         S_POW_A: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.result;
               if (esh_ff[FIELD_W-1:1] == '0) begin
                  esh_in   = '0;
                  state_in = S_POW;
               end else begin
                  mm_cmd.start        = 1'b1;
                  mm_cmd.multiplicand = b_ff;
                  mm_cmd.multiplier   = b_ff;
                  state_in            = S_POW_B;
               end
            end
         end
         S_POW_B: begin
            if (mm_rsp.done) begin
               b_in     = mm_rsp.result;
               esh_in   = {1'b0, esh_ff[FIELD_W-1:1]};
               state_in = S_POW;
            end
         end
         S_MULC: begin
            if (mm_rsp.done) begin
               t_in     = mm_rsp.result;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            wr_en    = 1'b1;
            wr_data  = '{seen: 1'b1, pos: pos_ff + field_type'(1), label: start_ff};
            pos_in   = pos_ff + field_type'(1);
            x_in     = nx;
            if (nx == '0) roots_in = roots_ff + field_type'(1);
            state_in = S_READ;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               o_roots_in    = roots_ff;
               o_cycles_in   = cycles_ff;
               o_periodic_in = periodic_ff;
               o_shortest_in = shortest_ff;
               o_longest_in  = longest_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[x_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         roots_ff     <= '0;
         cycles_ff    <= '0;
         periodic_ff  <= '0;
         shortest_ff  <= '0;
         longest_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         roots_ff     <= roots_in;
         cycles_ff    <= cycles_in;
         periodic_ff  <= periodic_in;
         shortest_ff  <= shortest_in;
         longest_ff   <= longest_in;
      end
      p_ff          <= p_in;
      a_ff          <= a_in;
      c_ff          <= c_in;
      d_ff          <= d_in;
      esh_ff        <= esh_in;
      acc_ff        <= acc_in;
      b_ff          <= b_in;
      t_ff          <= t_in;
      x_ff          <= x_in;
      pos_ff        <= pos_in;
      start_ff      <= start_in;
      o_roots_ff    <= o_roots_in;
      o_cycles_ff   <= o_cycles_in;
      o_periodic_ff <= o_periodic_in;
      o_shortest_ff <= o_shortest_in;
      o_longest_ff  <= o_longest_in;
   end

   assign req.ready           = (state_ff == S_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.root_count      = o_roots_ff;
   assign rsp.cycle_count     = o_cycles_ff;
   assign rsp.periodic_points = o_periodic_ff;
   assign rsp.shortest_cycle  = o_shortest_ff;
   assign rsp.longest_cycle   = o_longest_ff;

   a_x_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (x_ff < p_ff)) else $error("walk left the field");
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |-> (pos_ff < p_ff)) else $error("walk too long");
   a_cycle_order: assert property (@(posedge clock) disable iff (reset)
      (cycles_ff != '0) |-> (shortest_ff != '0 && shortest_ff <= longest_ff))
      else $error("cycle length bounds inconsistent");

endmodule
`default_nettype wire

>>> src/tmcs_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module tmcs_mulmod (
   input  wire                  clock,
   input  wire                  reset,
   input  tmcs_pkg::field_type  modulus,
   input  tmcs_pkg::mm_cmd_type cmd,
   output tmcs_pkg::mm_rsp_type rsp
);
   import tmcs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   field_type            r_ff, r_in;
   field_type            x_ff, x_in;
   field_type            y_ff, y_in;
   logic [FIELD_W+1:0]   t0, t1, t2, pm;

   always_comb begin
      pm = {2'b00, modulus};
      t0 = {1'b0, r_ff, 1'b0} + (y_ff[FIELD_W-1] ? {2'b00, x_ff} : '0);
      t1 = (t0 >= pm) ? t0 - pm : t0;
      t2 = (t1 >= pm) ? t1 - pm : t1;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (busy_ff) begin
         r_in   = t2[FIELD_W-1:0];
         y_in   = {y_ff[FIELD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FIELD_W - 1);
         r_in    = '0;
         x_in    = cmd.multiplicand;
         y_in    = cmd.multiplier;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.busy   = busy_ff;
   assign rsp.result = r_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff) else $error("multiply started while busy");
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      (done_ff && modulus != '0) |-> (r_ff < modulus)) else $error("result not reduced");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without work");

endmodule
`default_nettype wire
